/* hdl/pue_pkg.sv */
// Package: shared types, constants and byte helpers for the PNG stream encoder.
`default_nettype none
package pue_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned MAX_PIXELS    = 16777216;
  localparam int unsigned BLOCK_PAYLOAD = 65535;

  localparam logic        REG_IMAGE_WIDTH  = 1'b0;
  localparam logic        REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  typedef enum logic [1:0] {K_ERR, K_START, K_PAY} pue_kind_t;

  typedef enum logic [2:0] {P_IDLE, P_ERR, P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC} pue_phase_t;

  typedef enum logic [2:0] {C_IHDR, C_ZLIB, C_BLOCK, C_BYTE, C_ADLER, C_IEND} pue_chunk_t;

  // One queued work item for the back end.
  typedef struct packed {
    pue_kind_t   kind;
    logic [7:0]  value;
    logic        open;
    logic        final_blk;
    logic [15:0] count;
    logic        close;
    logic        eof;
    logic        last;
    logic [12:0] width;
    logic [12:0] height;
  } pue_entry_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [7:0] be32_byte(input logic [31:0] v, input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = v[31:24];
      2'd1: r = v[23:16];
      2'd2: r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'd137;
      3'd1: r = 8'd80;
      3'd2: r = 8'd78;
      3'd3: r = 8'd71;
      3'd4: r = 8'd13;
      3'd5: r = 8'd10;
      3'd6: r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] type_byte(input pue_chunk_t c, input logic [1:0] i);
    logic [31:0] t;
    unique case (c)
      C_IHDR:  t = 32'h49484452;
      C_IEND:  t = 32'h49454e44;
      default: t = 32'h49444154;
    endcase
    return be32_byte(t, i);
  endfunction

  function automatic logic [7:0] ihdr_byte(input logic [12:0] w, input logic [12:0] h,
                                           input logic [3:0] i);
    logic [7:0] r;
    unique case (i)
      4'd2:  r = {3'd0, w[12:8]};
      4'd3:  r = w[7:0];
      4'd6:  r = {3'd0, h[12:8]};
      4'd7:  r = h[7:0];
      4'd8:  r = 8'd8;
      4'd9:  r = 8'd6;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/png_uncompressed_rgba_encoder_core.sv */
// Top level: streaming PNG encoder for RGBA8 pixels with stored deflate blocks.
//
//   channel   direction  handshake              payload
//   config    in         wr_en                  wr_index, wr_data
//   pixels    in         data_valid/data_ready  data_byte
//   stream    out        out_valid/out_ready    out_byte, last_of_run, end_of_file, size_error
//
// An ordinary pixel byte gives one transfer out, a row start adds the filter byte, and file,
// block and trailer bursts (up to 47 bytes) are paced by the back-end byte sequencer at one
// byte per cycle while the stream side accepts bytes. The front end pushes one queue entry per
// pixel byte, plus a filter entry at a row start and a file-start entry at a file start; a
// four-entry queue lets it run ahead of the sequencer.
// Reset is synchronous; after it the block is idle with a width and height of one.
// A stall on the stream side holds the output register and fills the queue, then drops ready.
`default_nettype none
module png_uncompressed_rgba_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [12:0] wr_data,
  input  wire logic        data_valid,
  output logic             data_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_file,
  output logic             size_error
);

  pue_pkg::pue_entry_t push_entry;
  pue_pkg::pue_entry_t head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;

  // Front: latch geometry at file start, classify each byte into queue entries.
  pue_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .data_byte  (data_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  // Decouple the two halves so each may stall on its own.
  pue_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_valid),
    .head       (head)
  );

  // Back: emit chunk framing, checksums and payload one byte per transfer.
  pue_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .end_of_file (end_of_file),
    .size_error  (size_error)
  );

endmodule
`default_nettype wire

/* hdl/pue_front.sv */
// Front end: takes pixel bytes, tracks file geometry and splits them into queue entries.
`default_nettype none
module pue_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic                wr_index,
  input  wire logic [12:0]         wr_data,
  input  wire logic                data_valid,
  output logic                     data_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output pue_pkg::pue_entry_t      q_entry
);

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        h_valid;
  logic [7:0]  h_byte;
  logic        file_started, file_started_next;
  logic        filt_done, filt_done_next;
  logic [13:0] column_bytes, column_bytes_next;
  logic [14:0] row_length, row_length_next;
  logic [26:0] payload_left, payload_left_next;
  logic [15:0] block_left, block_left_next;

  logic [25:0] pixels;
  logic        geom_bad;
  logic [15:0] cnt;
  logic        open;
  logic [15:0] bl_eff;
  logic [15:0] bl_dec;
  logic [26:0] pl_dec;
  logic        is_filter;
  logic        consume;
  logic [14:0] col_inc;

  assign pixels   = {13'd0, image_width} * {13'd0, image_height};
  assign geom_bad = (image_width == 13'd0) || (image_height == 13'd0) ||
                    (image_width > 13'(pue_pkg::MAX_DIMENSION)) ||
                    (image_height > 13'(pue_pkg::MAX_DIMENSION)) ||
                    (pixels > 26'(pue_pkg::MAX_PIXELS));

  assign cnt     = (payload_left < 27'(pue_pkg::BLOCK_PAYLOAD)) ? payload_left[15:0]
                                                               : 16'(pue_pkg::BLOCK_PAYLOAD);
  assign open    = (block_left == 16'd0);
  assign bl_eff  = open ? cnt : block_left;
  assign bl_dec  = bl_eff - 16'd1;
  assign pl_dec  = payload_left - 27'd1;
  assign is_filter = (column_bytes == 14'd0) && !filt_done;
  assign col_inc = {1'b0, column_bytes} + 15'd1;

  assign q_push     = h_valid && !q_full;
  assign data_ready = !h_valid || (q_push && consume);

  always_comb begin
    q_entry           = '0;
    q_entry.kind      = pue_pkg::K_PAY;
    consume           = 1'b0;
    file_started_next = file_started;
    filt_done_next    = filt_done;
    column_bytes_next = column_bytes;
    row_length_next   = row_length;
    payload_left_next = payload_left;
    block_left_next   = block_left;
    if (!file_started) begin
      if (geom_bad) begin
        q_entry.kind = pue_pkg::K_ERR;
        q_entry.last = 1'b1;
        consume      = 1'b1;
      end else begin
        q_entry.kind      = pue_pkg::K_START;
        q_entry.width     = image_width;
        q_entry.height    = image_height;
        file_started_next = 1'b1;
        filt_done_next    = 1'b0;
        row_length_next   = {image_width[12:0], 2'b00};
        payload_left_next = {pixels[24:0], 2'b00} + {14'd0, image_height};
        block_left_next   = 16'd0;
        column_bytes_next = 14'd0;
      end
    end else begin
      q_entry.value     = is_filter ? 8'd0 : h_byte;
      q_entry.open      = open;
      q_entry.final_blk = (payload_left == {11'd0, cnt});
      q_entry.count     = cnt;
      q_entry.close     = (bl_dec == 16'd0);
      q_entry.eof       = (pl_dec == 27'd0);
      q_entry.last      = !is_filter;
      block_left_next   = bl_dec;
      payload_left_next = pl_dec;
      if (is_filter) begin
        filt_done_next = 1'b1;
      end else begin
        consume        = 1'b1;
        filt_done_next = 1'b0;
        column_bytes_next = (col_inc >= row_length) ? 14'd0 : col_inc[13:0];
      end
      if (pl_dec == 27'd0) begin
        file_started_next = 1'b0;
        column_bytes_next = 14'd0;
        block_left_next   = 16'd0;
        filt_done_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      h_valid      <= 1'b0;
      file_started <= 1'b0;
      filt_done    <= 1'b0;
      column_bytes <= '0;
      row_length   <= '0;
      payload_left <= '0;
      block_left   <= '0;
    end else begin
      if (wr_en) begin
        if (wr_index == pue_pkg::REG_IMAGE_WIDTH) image_width <= wr_data;
        else image_height <= wr_data;
      end
      if (data_valid && data_ready) begin
        h_valid <= 1'b1;
      end else if (q_push && consume) begin
        h_valid <= 1'b0;
      end
      if (q_push) begin
        file_started <= file_started_next;
        filt_done    <= filt_done_next;
        column_bytes <= column_bytes_next;
        row_length   <= row_length_next;
        payload_left <= payload_left_next;
        block_left   <= block_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) h_byte <= data_byte;
  end

endmodule
`default_nettype wire

/* hdl/pue_queue.sv */
// Short queue of work entries between the front and back ends.
`default_nettype none
module pue_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire pue_pkg::pue_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output pue_pkg::pue_entry_t       head
);

  pue_pkg::pue_entry_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  assign full      = (fill == 3'd4);
  assign not_empty = (fill != 3'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

/* hdl/pue_back.sv */
// Back end: expands queue entries into PNG bytes with CRC-32 and Adler-32.
`default_nettype none
module pue_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire pue_pkg::pue_entry_t  q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      last_of_run,
  output logic                      end_of_file,
  output logic                      size_error
);

  pue_pkg::pue_phase_t phase, phase_next;
  pue_pkg::pue_chunk_t chunk, chunk_next;
  logic [3:0]          idx, idx_next;
  pue_pkg::pue_entry_t ent;
  logic [31:0]         crc;
  logic [15:0]         adl_lo;
  logic [15:0]         adl_hi;

  logic        emit;
  logic        done;
  logic        load;
  logic [7:0]  byte_val;
  logic [31:0] len_val;
  logic [3:0]  last_idx;
  logic        crc_on;
  logic        adl_on;
  logic [31:0] crc_base;
  logic [16:0] lo_sum;
  logic [15:0] lo_new;
  logic [16:0] hi_sum;
  logic [15:0] hi_new;
  pue_pkg::pue_phase_t load_phase;
  pue_pkg::pue_chunk_t load_chunk;

  assign emit = (phase != pue_pkg::P_IDLE) && (!out_valid || out_ready);

  always_comb begin
    unique case (chunk)
      pue_pkg::C_IHDR:  len_val = 32'd13;
      pue_pkg::C_ZLIB:  len_val = 32'd2;
      pue_pkg::C_BLOCK: len_val = {16'd0, ent.count} + 32'd5;
      pue_pkg::C_ADLER: len_val = 32'd4;
      default:          len_val = 32'd0;
    endcase
  end

  // Output byte for the current position.
  always_comb begin
    byte_val = 8'd0;
    unique case (phase)
      pue_pkg::P_SIG:  byte_val = pue_pkg::sig_byte(idx[2:0]);
      pue_pkg::P_LEN:  byte_val = pue_pkg::be32_byte(len_val, idx[1:0]);
      pue_pkg::P_TYPE: byte_val = pue_pkg::type_byte(chunk, idx[1:0]);
      pue_pkg::P_CRC:  byte_val = pue_pkg::be32_byte(~crc, idx[1:0]);
      pue_pkg::P_DATA: begin
        unique case (chunk)
          pue_pkg::C_IHDR: byte_val = pue_pkg::ihdr_byte(ent.width, ent.height, idx);
          pue_pkg::C_ZLIB: byte_val = (idx == 4'd0) ? 8'h78 : 8'h01;
          pue_pkg::C_BLOCK: begin
            unique case (idx)
              4'd0: byte_val = {7'd0, ent.final_blk};
              4'd1: byte_val = ent.count[7:0];
              4'd2: byte_val = ent.count[15:8];
              4'd3: byte_val = ~ent.count[7:0];
              4'd4: byte_val = ~ent.count[15:8];
              default: byte_val = ent.value;
            endcase
          end
          pue_pkg::C_BYTE:  byte_val = ent.value;
          pue_pkg::C_ADLER: byte_val = pue_pkg::be32_byte({adl_hi, adl_lo}, idx[1:0]);
          default:          byte_val = 8'd0;
        endcase
      end
      default: byte_val = 8'd0;
    endcase
  end

  always_comb begin
    unique case (phase)
      pue_pkg::P_SIG: last_idx = 4'd7;
      pue_pkg::P_LEN, pue_pkg::P_TYPE, pue_pkg::P_CRC: last_idx = 4'd3;
      pue_pkg::P_DATA: begin
        unique case (chunk)
          pue_pkg::C_IHDR:  last_idx = 4'd12;
          pue_pkg::C_ZLIB:  last_idx = 4'd1;
          pue_pkg::C_BLOCK: last_idx = 4'd5;
          pue_pkg::C_ADLER: last_idx = 4'd3;
          default:          last_idx = 4'd0;
        endcase
      end
      default: last_idx = 4'd0;
    endcase
  end

  // Next position within the entry.
  always_comb begin
    phase_next = phase;
    chunk_next = chunk;
    idx_next   = idx + 4'd1;
    done       = 1'b0;
    if (idx == last_idx) begin
      idx_next = 4'd0;
      unique case (phase)
        pue_pkg::P_SIG: begin
          phase_next = pue_pkg::P_LEN;
          chunk_next = pue_pkg::C_IHDR;
        end
        pue_pkg::P_LEN:  phase_next = pue_pkg::P_TYPE;
        pue_pkg::P_TYPE: phase_next = (chunk == pue_pkg::C_IEND) ? pue_pkg::P_CRC
                                                                 : pue_pkg::P_DATA;
        pue_pkg::P_DATA: begin
          if ((chunk == pue_pkg::C_BLOCK || chunk == pue_pkg::C_BYTE) && !ent.close) begin
            done = 1'b1;
          end else begin
            phase_next = pue_pkg::P_CRC;
          end
        end
        pue_pkg::P_CRC: begin
          unique case (chunk)
            pue_pkg::C_IHDR: begin
              phase_next = pue_pkg::P_LEN;
              chunk_next = pue_pkg::C_ZLIB;
            end
            pue_pkg::C_ADLER: begin
              phase_next = pue_pkg::P_LEN;
              chunk_next = pue_pkg::C_IEND;
            end
            pue_pkg::C_BLOCK, pue_pkg::C_BYTE: begin
              if (ent.eof) begin
                phase_next = pue_pkg::P_LEN;
                chunk_next = pue_pkg::C_ADLER;
              end else begin
                done = 1'b1;
              end
            end
            default: done = 1'b1;
          endcase
        end
        default: done = 1'b1;
      endcase
    end
  end

  always_comb begin
    load_chunk = pue_pkg::C_BYTE;
    unique case (q_head.kind)
      pue_pkg::K_ERR:   load_phase = pue_pkg::P_ERR;
      pue_pkg::K_START: load_phase = pue_pkg::P_SIG;
      default: begin
        load_phase = q_head.open ? pue_pkg::P_LEN : pue_pkg::P_DATA;
        load_chunk = q_head.open ? pue_pkg::C_BLOCK : pue_pkg::C_BYTE;
      end
    endcase
  end

  assign load  = q_valid && ((phase == pue_pkg::P_IDLE) || (emit && done));
  assign q_pop = load;

  assign crc_on   = emit && ((phase == pue_pkg::P_TYPE) || (phase == pue_pkg::P_DATA));
  assign crc_base = ((phase == pue_pkg::P_TYPE) && (idx == 4'd0)) ? pue_pkg::CRC_INIT : crc;
  assign adl_on   = emit && (phase == pue_pkg::P_DATA) &&
                    (((chunk == pue_pkg::C_BYTE) && (idx == 4'd0)) ||
                     ((chunk == pue_pkg::C_BLOCK) && (idx == 4'd5)));
  assign lo_sum   = {1'b0, adl_lo} + {9'd0, ent.value};
  assign lo_new   = (lo_sum >= pue_pkg::ADLER_MOD) ? 16'(lo_sum - pue_pkg::ADLER_MOD)
                                                   : lo_sum[15:0];
  assign hi_sum   = {1'b0, adl_hi} + {1'b0, lo_new};
  assign hi_new   = (hi_sum >= pue_pkg::ADLER_MOD) ? 16'(hi_sum - pue_pkg::ADLER_MOD)
                                                   : hi_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= pue_pkg::P_IDLE;
      chunk     <= pue_pkg::C_BYTE;
      idx       <= '0;
      out_valid <= 1'b0;
      crc       <= pue_pkg::CRC_INIT;
      adl_lo    <= 16'd1;
      adl_hi    <= 16'd0;
    end else begin
      if (load) begin
        phase <= load_phase;
        chunk <= load_chunk;
        idx   <= '0;
      end else if (emit) begin
        phase <= done ? pue_pkg::P_IDLE : phase_next;
        chunk <= chunk_next;
        idx   <= idx_next;
      end
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (crc_on) crc <= pue_pkg::crc_step(crc_base, byte_val);
      if (load && (q_head.kind == pue_pkg::K_START)) begin
        adl_lo <= 16'd1;
        adl_hi <= 16'd0;
      end else if (adl_on) begin
        adl_lo <= lo_new;
        adl_hi <= hi_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) ent <= q_head;
    if (emit) begin
      out_byte    <= byte_val;
      last_of_run <= done && ent.last;
      end_of_file <= (phase == pue_pkg::P_CRC) && (chunk == pue_pkg::C_IEND) &&
                     (idx == 4'd3);
      size_error  <= (phase == pue_pkg::P_ERR);
    end
  end

endmodule
`default_nettype wire

/* hdl/pue_checker.sv */
// Port-level checker for the PNG stream encoder, bound to the top level.
`default_nettype none
module pue_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last_of_run,
  input wire logic       end_of_file,
  input wire logic       size_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("stalled transfer changed");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && size_error |-> out_byte == 8'd0 && last_of_run && !end_of_file)
    else $error("size error transfer malformed");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_file |-> last_of_run && !size_error)
    else $error("end of file not last of run");

  a_eof_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && end_of_file |=> !(out_valid && end_of_file))
    else $error("two end of file transfers in a row");

endmodule

bind png_uncompressed_rgba_encoder_core pue_checker u_pue_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .end_of_file (end_of_file),
  .size_error  (size_error)
);
`default_nettype wire
